// ===== hdl/h2t_pkg.sv =====
// Shared types and constants for the HTML to plain text stream unit.
// No dependencies; imported by every module of the unit.
`default_nettype none
package h2t_pkg;

	localparam int TAG_NAME_MAX_DEF = 31;
	localparam int Q_DEPTH = 2;
	localparam int BURST_MAX = 5;

	// parser modes
	localparam logic [3:0] M_TEXT      = 4'd0;
	localparam logic [3:0] M_COLLAPSE  = 4'd1;
	localparam logic [3:0] M_TAG_START = 4'd2;
	localparam logic [3:0] M_TAG_NAME  = 4'd3;
	localparam logic [3:0] M_TAG_SKIP  = 4'd4;
	localparam logic [3:0] M_ENT       = 4'd5;
	localparam logic [3:0] M_NUM_START = 4'd6;
	localparam logic [3:0] M_NUM_DEC   = 4'd7;
	localparam logic [3:0] M_NUM_HEX   = 4'd8;

	localparam logic [16:0] CP_SAT = 17'h1FFFF;

	// named entities, byte k of the name at bits 8k
	localparam logic [5:0][39:0] ENT_NAME = {
		40'h3b7073626e, 40'h3b736f7061, 40'h3b746f7571,
		40'h00003b7467, 40'h00003b746c, 40'h003b706d61};
	localparam logic [5:0][2:0] ENT_LEN = {3'd5, 3'd5, 3'd5, 3'd3, 3'd3, 3'd4};
	localparam logic [5:0][7:0] ENT_CHAR = {8'h20, 8'h27, 8'h22, 8'h3e, 8'h3c, 8'h26};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// all result bytes of one input byte, byte k at bits 8k
	typedef struct packed {
		logic [2:0]  count;
		logic [39:0] bytes;
	} burst_t;

endpackage
`default_nettype wire

// ===== hdl/html_to_plain_text_stream_unit.sv =====
// Top level of the HTML to plain text stream unit.
// Depends on h2t_pkg, h2t_front and h2t_back.
`default_nettype none
// The unit takes one HTML byte per cycle and yields plain text bytes: tags
// are stripped (some become line breaks), entities and numeric references
// are decoded to UTF-8, and newline runs collapse to one space outside pre.
// Each input transaction yields zero to five result bytes; run_last marks the
// last one of a transaction. The front parser decides all bytes of an input
// in the cycle it is accepted and writes them as one burst into a two-entry
// queue; the back end then delivers one byte per cycle while popped. An input
// that yields one byte thus flows at one transaction per cycle, while an
// input that yields n bytes holds the output until all n are popped, so the
// input stalls (full) once the queue holds two bursts. Inputs yielding no
// bytes write nothing into the queue, but they too wait while it is full.
// end_of_input flushes any open tag or reference and returns the parser,
// preformatted mode included, to its reset state.
module html_to_plain_text_stream_unit import h2t_pkg::*; #(
	parameter int TAG_NAME_MAX = TAG_NAME_MAX_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	logic   take;
	logic   burst_valid;
	burst_t burst;

	// accept an input transaction whenever the queue has room
	assign take = push && !full;

	h2t_front #(
		.TAG_NAME_MAX(TAG_NAME_MAX)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.item(item),
		.burst(burst),
		.burst_valid(burst_valid)
	);

	h2t_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr(burst_valid),
		.wr_burst(burst),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	// a queued burst always carries one to five bytes
	a_burst_size: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid |-> (burst.count != 3'd0 && burst.count <= 3'(BURST_MAX)))
		else $error("burst size out of range");

	// a full queue always has a result on offer
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full queue reports empty");

	// the queue fills only after an accepted input
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("queue filled without an input");

endmodule
`default_nettype wire

// ===== hdl/h2t_front.sv =====
// Front end: parses one HTML byte per accepted transaction into a burst.
// Depends on h2t_pkg.
`default_nettype none
module h2t_front import h2t_pkg::*; #(
	parameter int TAG_NAME_MAX = TAG_NAME_MAX_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     take,
	input  wire in_item_t item,
	output burst_t        burst,
	output logic          burst_valid
);

	localparam int TAG_CAP_I = (TAG_NAME_MAX < 31) ? TAG_NAME_MAX : 31;
	localparam logic [4:0] TAG_CAP = 5'(TAG_CAP_I);

	typedef struct packed {
		logic [3:0]  mode;
		logic        closing;
		logic [23:0] head;
		logic [4:0]  tlen;
		logic        pre;
		logic [31:0] epre;
		logic [2:0]  elen;
		logic [16:0] cp;
		logic [63:0] obuf;
		logic [3:0]  ocnt;
	} ctx_t;

	ctx_t cur, nxt;
	logic [3:0]  mode_q;
	logic        closing_q;
	logic [23:0] head_q;
	logic [4:0]  tlen_q;
	logic        pre_q;
	logic [31:0] epre_q;
	logic [2:0]  elen_q;
	logic [16:0] cp_q;

	function automatic ctx_t put(ctx_t x, logic [7:0] c);
		if (x.ocnt < 4'd8) begin
			x.obuf[8*x.ocnt[2:0] +: 8] = c;
			x.ocnt = x.ocnt + 4'd1;
		end
		return x;
	endfunction

	function automatic ctx_t text_byte(ctx_t x, logic [7:0] c);
		if (c == 8'h3c) begin
			x.mode = M_TAG_START;
			x.closing = 1'b0;
			x.head = '0;
			x.tlen = '0;
		end else if (c == 8'h26) begin
			x.mode = M_ENT;
			x.epre = '0;
			x.elen = '0;
		end else if (!x.pre && (c == 8'h0d || c == 8'h0a)) begin
			x = put(x, 8'h20);
			x.mode = M_COLLAPSE;
		end else begin
			x = put(x, c);
		end
		return x;
	endfunction

	function automatic ctx_t eval_tag(ctx_t x);
		logic t2, t1, t3;
		t1 = x.tlen == 5'd1;
		t2 = x.tlen == 5'd2;
		t3 = x.tlen == 5'd3;
		if (t2 && x.head[15:0] == 16'h7262) begin
			x = put(x, 8'h0a);
		end else if (t1 && x.head[7:0] == 8'h70) begin
			if (!x.closing) begin
				x = put(x, 8'h0a);
				x = put(x, 8'h0a);
			end
		end else if (t3 && x.head == 24'h766964) begin
			if (!x.closing) x = put(x, 8'h0a);
		end else if (t2 && x.head[15:0] == 16'h696c) begin
			if (!x.closing) begin
				x = put(x, 8'h0a);
				x = put(x, 8'h2d);
				x = put(x, 8'h20);
			end
		end else if (t2 && x.head[15:0] == 16'h7268) begin
			x = put(x, 8'h0a);
			x = put(x, 8'h2d);
			x = put(x, 8'h2d);
			x = put(x, 8'h2d);
			x = put(x, 8'h0a);
		end else if (t3 && x.head == 24'h657270) begin
			x.pre = !x.closing;
		end else if (t2 && (x.head[15:0] == 16'h3168 || x.head[15:0] == 16'h3268 ||
				x.head[15:0] == 16'h3368)) begin
			x = put(x, 8'h0a);
			if (!x.closing) x = put(x, 8'h0a);
		end
		x.mode = M_TEXT;
		return x;
	endfunction

	function automatic ctx_t tag_name_byte(ctx_t x, logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
		if (c == 8'h3e) begin
			x = eval_tag(x);
		end else if (c == 8'h20) begin
			x.mode = M_TAG_SKIP;
		end else begin
			if (x.tlen < 5'd3) x.head[8*x.tlen[1:0] +: 8] = lc;
			if (x.tlen < TAG_CAP) x.tlen = x.tlen + 5'd1;
			x.mode = (x.tlen >= TAG_CAP) ? M_TAG_SKIP : M_TAG_NAME;
		end
		return x;
	endfunction

	function automatic ctx_t replay(ctx_t x);
		logic [2:0] n;
		n = (x.elen > 3'd4) ? 3'd4 : x.elen;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < n) x = put(x, x.epre[8*k +: 8]);
		end
		x.epre = '0;
		x.elen = '0;
		return x;
	endfunction

	function automatic ctx_t entity_byte(ctx_t x, logic [7:0] c);
		logic [2:0] n;
		logic       hit, partial, ok;
		logic [7:0] hit_c;
		n = (x.elen > 3'd4) ? 3'd4 : x.elen;
		hit = 1'b0;
		partial = 1'b0;
		hit_c = '0;
		for (int i = 0; i < 6; i++) begin
			ok = ENT_LEN[i] > n && ENT_NAME[i][8*n +: 8] == c;
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < n && x.epre[8*k +: 8] != ENT_NAME[i][8*k +: 8]) ok = 1'b0;
			end
			if (ok && n + 3'd1 == ENT_LEN[i]) begin
				hit = 1'b1;
				hit_c = ENT_CHAR[i];
			end else if (ok) begin
				partial = 1'b1;
			end
		end
		if (n == 3'd0 && c == 8'h23) begin
			x.mode = M_NUM_START;
			x.cp = '0;
		end else if (hit) begin
			x = put(x, hit_c);
			x.epre = '0;
			x.elen = '0;
			x.mode = M_TEXT;
		end else if (partial && n < 3'd4) begin
			x.epre[8*n[1:0] +: 8] = c;
			x.elen = n + 3'd1;
		end else begin
			x = replay(x);
			x.mode = M_TEXT;
			x = text_byte(x, c);
		end
		return x;
	endfunction

	function automatic ctx_t emit_utf8(ctx_t x);
		if (x.cp < 17'h80) begin
			x = put(x, x.cp[7:0]);
		end else if (x.cp < 17'h800) begin
			x = put(x, {3'b110, x.cp[10:6]});
			x = put(x, {2'b10, x.cp[5:0]});
		end else if (x.cp < 17'h10000) begin
			x = put(x, {4'b1110, x.cp[15:12]});
			x = put(x, {2'b10, x.cp[11:6]});
			x = put(x, {2'b10, x.cp[5:0]});
		end
		return x;
	endfunction

	function automatic ctx_t numeric_byte(ctx_t x, logic [7:0] c);
		logic        hex, dv;
		logic [3:0]  d;
		logic [21:0] v;
		hex = x.mode == M_NUM_HEX;
		dv = 1'b1;
		d = '0;
		if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
		else if (hex && c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
		else if (hex && c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
		else dv = 1'b0;
		v = (hex ? {1'b0, x.cp, 4'b0} : 22'(x.cp) * 22'd10) + 22'(d);
		if (x.mode == M_NUM_START && (c == 8'h78 || c == 8'h58)) begin
			x.mode = M_NUM_HEX;
		end else if (dv) begin
			x.cp = (v > 22'(CP_SAT)) ? CP_SAT : v[16:0];
			if (x.mode == M_NUM_START) x.mode = M_NUM_DEC;
		end else begin
			x = emit_utf8(x);
			x.cp = '0;
			x.mode = M_TEXT;
			if (c != 8'h3b) x = text_byte(x, c);
		end
		return x;
	endfunction

	always_comb begin
		cur = '0;
		cur.mode = mode_q;
		cur.closing = closing_q;
		cur.head = head_q;
		cur.tlen = tlen_q;
		cur.pre = pre_q;
		cur.epre = epre_q;
		cur.elen = elen_q;
		cur.cp = cp_q;
		nxt = cur;
		unique case (cur.mode)
			M_COLLAPSE: begin
				if (!(item.in_byte == 8'h0d || item.in_byte == 8'h0a ||
						item.in_byte == 8'h20 || item.in_byte == 8'h09)) begin
					nxt.mode = M_TEXT;
					nxt = text_byte(nxt, item.in_byte);
				end
			end
			M_TAG_START: begin
				if (item.in_byte == 8'h2f) begin
					nxt.closing = 1'b1;
					nxt.mode = M_TAG_NAME;
				end else begin
					nxt = tag_name_byte(nxt, item.in_byte);
				end
			end
			M_TAG_NAME: nxt = tag_name_byte(nxt, item.in_byte);
			M_TAG_SKIP: if (item.in_byte == 8'h3e) nxt = eval_tag(nxt);
			M_ENT: nxt = entity_byte(nxt, item.in_byte);
			M_NUM_START, M_NUM_DEC, M_NUM_HEX: nxt = numeric_byte(nxt, item.in_byte);
			default: begin
				nxt.mode = M_TEXT;
				nxt = text_byte(nxt, item.in_byte);
			end
		endcase
		if (item.end_of_input) begin
			priority case (nxt.mode)
				M_TAG_START, M_TAG_NAME, M_TAG_SKIP: nxt = eval_tag(nxt);
				M_ENT: nxt = replay(nxt);
				M_NUM_START, M_NUM_DEC, M_NUM_HEX: nxt = emit_utf8(nxt);
				default: ;
			endcase
			nxt.mode = M_TEXT;
			nxt.closing = 1'b0;
			nxt.head = '0;
			nxt.tlen = '0;
			nxt.pre = 1'b0;
			nxt.epre = '0;
			nxt.elen = '0;
			nxt.cp = '0;
		end
		burst.bytes = nxt.obuf[39:0];
		burst.count = (nxt.ocnt > 4'(BURST_MAX)) ? 3'(BURST_MAX) : nxt.ocnt[2:0];
		burst_valid = take && burst.count != 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_TEXT;
			closing_q <= 1'b0;
			head_q <= '0;
			tlen_q <= '0;
			pre_q <= 1'b0;
			epre_q <= '0;
			elen_q <= '0;
			cp_q <= '0;
		end else if (take) begin
			mode_q <= nxt.mode;
			closing_q <= nxt.closing;
			head_q <= nxt.head;
			tlen_q <= nxt.tlen;
			pre_q <= nxt.pre;
			epre_q <= nxt.epre;
			elen_q <= nxt.elen;
			cp_q <= nxt.cp;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/h2t_back.sv =====
// Back end: holds bursts in a short queue and hands out one byte per pop.
// Depends on h2t_pkg.
`default_nettype none
module h2t_back import h2t_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr,
	input  wire burst_t wr_burst,
	output logic        full,
	output logic        empty,
	input  wire logic   pop,
	output out_item_t   result
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	burst_t         mem_q [Q_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic [2:0]     idx_q;
	burst_t         head;
	logic           last_byte, done;

	assign head = mem_q[rd_ptr_q];
	assign full = cnt_q == CW'(Q_DEPTH);
	assign empty = cnt_q == '0;
	assign last_byte = idx_q == head.count - 3'd1;
	assign done = pop && !empty && last_byte;
	assign result.out_byte = head.bytes[8*idx_q +: 8];
	assign result.run_last = last_byte;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wr_burst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (wr) wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (done) rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			// advance within the burst, drop the burst on its last byte
			if (pop && !empty) idx_q <= last_byte ? 3'd0 : idx_q + 3'd1;
			cnt_q <= cnt_q + CW'(wr) - CW'(done);
		end
	end

endmodule
`default_nettype wire
